// ===== hw/rtl/ffm_pkg.sv =====
// ----------------------------------------------------------------------------
// ffm_pkg
// Shared types, codes and constants of the flight fault monitor.
// ----------------------------------------------------------------------------
package ffm_pkg;

    // default width of the time base and of the stored timestamps
    localparam int DEF_TIME_BITS = 48;

    // width of the timestamp field of an input word
    localparam int NOW_W = 48;

    // millisecond thresholds are kept scaled to microseconds
    localparam int US_PER_MS = 1000;
    localparam int THR_US_W  = 26;

    // register reset values
    localparam logic [14:0] RST_TILT_LIMIT_CDEG   = 15'd4500;
    localparam logic [15:0] RST_MOTOR_SAT_LIMIT_MS = 16'd500;
    localparam logic [15:0] RST_HEARTBEAT_TIMEOUT_MS = 16'd1000;
    localparam logic [15:0] RST_BATTERY_FLOOR_MV  = 16'd3300;
    localparam logic [7:0]  RST_MISS_STREAK_LIMIT = 8'd5;
    localparam logic [15:0] RST_BATTERY_HOLD_MS   = 16'd1000;

    // imu status codes
    localparam logic [1:0] IMU_FRESH   = 2'd0;
    localparam logic [1:0] IMU_DATED   = 2'd1;
    localparam logic [1:0] IMU_INVALID = 2'd2;

    // flight modes
    typedef enum logic [2:0] {
        MODE_DISARMED   = 3'd0,
        MODE_ARMED      = 3'd1,
        MODE_TAKING_OFF = 3'd2,
        MODE_HOLDING    = 3'd3,
        MODE_FLYING     = 3'd4,
        MODE_LANDING    = 3'd5,
        MODE_EMERGENCY  = 3'd6,
        MODE_BENCH_RAMP = 3'd7
    } t_mode;

    // fault levels
    typedef enum logic [1:0] {
        LVL_NONE = 2'd0,
        LVL_SOFT = 2'd1,
        LVL_HARD = 2'd2
    } t_level;

    // fault reasons
    typedef enum logic [3:0] {
        RSN_OK           = 4'd0,
        RSN_IMU_INVALID  = 4'd1,
        RSN_TILT         = 4'd2,
        RSN_DEADLINE     = 4'd3,
        RSN_MOTOR_SAT    = 4'd4,
        RSN_IMU_DATED    = 4'd5,
        RSN_HB_TAKEOFF   = 4'd6,
        RSN_HB           = 4'd7,
        RSN_BATTERY      = 4'd8,
        RSN_ALT_LOST     = 4'd9,
        RSN_ALT_DEGRADED = 4'd10
    } t_reason;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_TILT_LIMIT   = 3'd0,
        REG_MOTOR_SAT    = 3'd1,
        REG_HB_TIMEOUT   = 3'd2,
        REG_BATT_FLOOR   = 3'd3,
        REG_STREAK_LIMIT = 3'd4,
        REG_BATT_HOLD    = 3'd5
    } t_reg_idx;

    // input word, last member in the lowest bits so it casts straight from tdata
    typedef struct packed {
        logic               heartbeat_seen;
        logic [NOW_W-1:0]   now_us;
        logic               altitude_degraded;
        logic               altitude_lost;
        logic [15:0]        battery_mv;
        logic               motor_at_limit;
        logic [7:0]         miss_streak;
        logic signed [15:0] pitch_cdeg;
        logic signed [15:0] roll_cdeg;
        logic [1:0]         imu_status;
        logic               airborne_flag;
        t_mode              fsm_mode;
    } t_sample;

    // result word, level in the lowest bits
    typedef struct packed {
        t_reason fault_reason;
        t_level  fault_level;
    } t_result;

    // thresholds as the checks use them
    typedef struct packed {
        logic [14:0]         tilt_limit_cdeg;
        logic [THR_US_W-1:0] motor_sat_limit_us;
        logic [THR_US_W-1:0] heartbeat_timeout_us;
        logic [15:0]         battery_floor_mv;
        logic [7:0]          miss_streak_limit;
        logic [THR_US_W-1:0] battery_hold_us;
    } t_cfg;

    // milliseconds to microseconds, constant multiply
    function automatic logic [THR_US_W-1:0] ms_to_us(input logic [15:0] ms);
        return THR_US_W'(ms) * THR_US_W'(US_PER_MS);
    endfunction

endpackage

// ===== hw/rtl/ffm_check.sv =====
// ----------------------------------------------------------------------------
// ffm_check
// Priority-ordered fault checks for one sample, with the next timer values.
// ----------------------------------------------------------------------------
module ffm_check #(
    parameter int TIME_BITS = ffm_pkg::DEF_TIME_BITS
) (
    input  ffm_pkg::t_sample       i_sample,
    input  ffm_pkg::t_cfg          i_cfg,
    input  logic [TIME_BITS-1:0]   i_last_hb,
    input  logic [TIME_BITS-1:0]   i_motor_start,
    input  logic [TIME_BITS-1:0]   i_batt_start,
    output logic [TIME_BITS-1:0]   o_last_hb,
    output logic [TIME_BITS-1:0]   o_motor_start,
    output logic [TIME_BITS-1:0]   o_batt_start,
    output ffm_pkg::t_result       o_result
);
    import ffm_pkg::*;

    logic [63:0]          now_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] hb_t;
    logic [TIME_BITS-1:0] mot_eff;
    logic [TIME_BITS-1:0] batt_eff;
    logic [TIME_BITS-1:0] mot_thr;
    logic [TIME_BITS-1:0] hb_thr;
    logic [TIME_BITS-1:0] hold_thr;
    logic [16:0]          abs_roll;
    logic [16:0]          abs_pitch;
    logic                 airborne;
    logic                 no_land_emerg;
    logic                 imu_bad;
    logic                 tilt_trip;
    logic                 streak_trip;
    logic                 mot_on;
    logic                 mot_trip;
    logic                 stale_trip;
    logic                 hb_trip;
    logic                 batt_check;
    logic                 batt_low;
    logic                 batt_trip;
    logic                 alt_lost_trip;
    logic                 alt_deg_trip;

    // time base, truncated or zero-extended to the timer width
    assign now_ext = 64'(i_sample.now_us);
    assign now_t   = now_ext[TIME_BITS-1:0];

    // heartbeat recorded before any check
    assign hb_t      = i_sample.heartbeat_seen ? now_t : i_last_hb;
    assign o_last_hb = hb_t;

    assign mot_thr  = TIME_BITS'(i_cfg.motor_sat_limit_us);
    assign hb_thr   = TIME_BITS'(i_cfg.heartbeat_timeout_us);
    assign hold_thr = TIME_BITS'(i_cfg.battery_hold_us);

    // mode gating
    assign airborne = i_sample.airborne_flag || (i_sample.fsm_mode == MODE_HOLDING)
                   || (i_sample.fsm_mode == MODE_FLYING)
                   || (i_sample.fsm_mode == MODE_LANDING);
    assign no_land_emerg = (i_sample.fsm_mode != MODE_LANDING)
                        && (i_sample.fsm_mode != MODE_EMERGENCY);

    // attitude magnitudes, the most negative value maps to 32768
    assign abs_roll  = i_sample.roll_cdeg[15]
                     ? 17'h10000 - {1'b0, i_sample.roll_cdeg}
                     : {1'b0, i_sample.roll_cdeg};
    assign abs_pitch = i_sample.pitch_cdeg[15]
                     ? 17'h10000 - {1'b0, i_sample.pitch_cdeg}
                     : {1'b0, i_sample.pitch_cdeg};

    // hard checks
    assign imu_bad     = (i_sample.imu_status >= IMU_INVALID);
    assign tilt_trip   = (abs_roll > {2'b00, i_cfg.tilt_limit_cdeg})
                      || (abs_pitch > {2'b00, i_cfg.tilt_limit_cdeg});
    assign streak_trip = (i_sample.miss_streak >= i_cfg.miss_streak_limit);

    // motor saturation timer, an idle timer starts now
    assign mot_on   = airborne && i_sample.motor_at_limit;
    assign mot_eff  = (i_motor_start == '0) ? now_t : i_motor_start;
    assign mot_trip = (now_t >= mot_eff) && ((now_t - mot_eff) > mot_thr);

    // soft checks
    assign stale_trip = (i_sample.imu_status == IMU_DATED) && no_land_emerg;
    assign hb_trip    = (now_t >= hb_t) && ((now_t - hb_t) > hb_thr) && no_land_emerg;

    // battery hold timer, a zero sample is ignored
    assign batt_check = (i_sample.fsm_mode != MODE_LANDING) && (i_sample.battery_mv != '0);
    assign batt_low   = (i_sample.battery_mv <= i_cfg.battery_floor_mv);
    assign batt_eff   = (i_batt_start == '0) ? now_t : i_batt_start;
    assign batt_trip  = (now_t >= batt_eff) ? ((now_t - batt_eff) >= hold_thr)
                                            : (hold_thr == '0);

    assign alt_lost_trip = i_sample.altitude_lost
                        && (i_sample.fsm_mode != MODE_LANDING)
                        && (i_sample.fsm_mode != MODE_BENCH_RAMP)
                        && (i_sample.fsm_mode != MODE_ARMED);
    assign alt_deg_trip  = airborne && i_sample.altitude_degraded;

    // first tripping check wins, timers move only when reached
    always_comb begin
        o_result.fault_level  = LVL_NONE;
        o_result.fault_reason = RSN_OK;
        o_motor_start         = i_motor_start;
        o_batt_start          = i_batt_start;
        if (i_sample.fsm_mode == MODE_DISARMED) begin
            o_motor_start = '0;
        end else if (imu_bad) begin
            o_result.fault_level  = LVL_HARD;
            o_result.fault_reason = RSN_IMU_INVALID;
        end else if (tilt_trip) begin
            o_result.fault_level  = LVL_HARD;
            o_result.fault_reason = RSN_TILT;
        end else if (streak_trip) begin
            o_result.fault_level  = LVL_HARD;
            o_result.fault_reason = RSN_DEADLINE;
        end else begin
            o_motor_start = mot_on ? mot_eff : '0;
            if (mot_on && mot_trip) begin
                o_result.fault_level  = LVL_HARD;
                o_result.fault_reason = RSN_MOTOR_SAT;
            end else if (stale_trip) begin
                o_result.fault_level  = LVL_SOFT;
                o_result.fault_reason = RSN_IMU_DATED;
            end else if (hb_trip) begin
                o_result.fault_level  = LVL_SOFT;
                o_result.fault_reason = (i_sample.fsm_mode == MODE_TAKING_OFF)
                                      ? RSN_HB_TAKEOFF : RSN_HB;
            end else begin
                if (batt_check) begin
                    o_batt_start = batt_low ? batt_eff : '0;
                end
                if (batt_check && batt_low && batt_trip) begin
                    o_result.fault_level  = LVL_SOFT;
                    o_result.fault_reason = RSN_BATTERY;
                end else if (alt_lost_trip) begin
                    o_result.fault_level  = LVL_SOFT;
                    o_result.fault_reason = RSN_ALT_LOST;
                end else if (alt_deg_trip) begin
                    o_result.fault_level  = LVL_SOFT;
                    o_result.fault_reason = RSN_ALT_DEGRADED;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/flight_fault_monitor.sv =====
// ----------------------------------------------------------------------------
// flight_fault_monitor
// Per-tick flight fault arbiter: one status word in, one fault word out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one flight-status word per control tick; m_axis returns
//   one fault word (level and reason) for every word taken, in order.
//   Thresholds sit in six APB registers at byte addresses 0x00 to 0x14;
//   write them only while no word is in flight. pready is tied high.
// Pipeline: the word passes the input register, then the result register.
// Throughput: one word per cycle while m_axis is not held off. The checks
//   and the three timestamp timers are a single combinational pass between
//   the two registers, and the timers update as the word moves into the
//   result register.
// Stall: while m_axis is held off the result register keeps its word and
//   one more word waits in the input register; s_axis_tready then drops.
// Reset: registers return to their defaults, the heartbeat time and both
//   timers clear to zero (timers idle) and both channels empty.
// ----------------------------------------------------------------------------
module flight_fault_monitor #(
    parameter int TIME_BITS = ffm_pkg::DEF_TIME_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] fsm_mode, [3] airborne_flag, [5:4] imu_status, [21:6] roll_cdeg,
    // [37:22] pitch_cdeg, [45:38] miss_streak, [46] motor_at_limit,
    // [62:47] battery_mv, [63] altitude_lost, [64] altitude_degraded,
    // [112:65] now_us, [113] heartbeat_seen, [119:114] zero
    input  logic [119:0] s_axis_tdata,
    // result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] fault_level, [5:2] fault_reason, [7:6] zero
    output logic [7:0]   m_axis_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ffm_pkg::*;

    localparam int SAMPLE_W = $bits(t_sample);

    // configuration registers
    logic [14:0]         r_tilt_limit;
    logic [15:0]         r_motor_sat_ms;
    logic [15:0]         r_hb_timeout_ms;
    logic [15:0]         r_batt_floor;
    logic [7:0]          r_streak_limit;
    logic [15:0]         r_batt_hold_ms;
    logic [THR_US_W-1:0] r_motor_sat_us;
    logic [THR_US_W-1:0] r_hb_timeout_us;
    logic [THR_US_W-1:0] r_batt_hold_us;
    t_cfg                cfg;
    t_reg_idx            reg_idx;
    logic                cfg_wr;

    // datapath
    logic                 r_in_valid;
    t_sample              r_in;
    logic                 r_out_valid;
    t_result              r_out;
    logic [TIME_BITS-1:0] r_last_hb;
    logic [TIME_BITS-1:0] r_motor_start;
    logic [TIME_BITS-1:0] r_batt_start;
    logic [TIME_BITS-1:0] n_last_hb;
    logic [TIME_BITS-1:0] n_motor_start;
    logic [TIME_BITS-1:0] n_batt_start;
    t_result              n_out;
    logic                 advance;
    logic                 in_accept;

    // register access
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_limit    <= RST_TILT_LIMIT_CDEG;
            r_motor_sat_ms  <= RST_MOTOR_SAT_LIMIT_MS;
            r_hb_timeout_ms <= RST_HEARTBEAT_TIMEOUT_MS;
            r_batt_floor    <= RST_BATTERY_FLOOR_MV;
            r_streak_limit  <= RST_MISS_STREAK_LIMIT;
            r_batt_hold_ms  <= RST_BATTERY_HOLD_MS;
            r_motor_sat_us  <= ms_to_us(RST_MOTOR_SAT_LIMIT_MS);
            r_hb_timeout_us <= ms_to_us(RST_HEARTBEAT_TIMEOUT_MS);
            r_batt_hold_us  <= ms_to_us(RST_BATTERY_HOLD_MS);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TILT_LIMIT: begin
                    r_tilt_limit <= pwdata[14:0];
                end
                REG_MOTOR_SAT: begin
                    r_motor_sat_ms <= pwdata[15:0];
                    r_motor_sat_us <= ms_to_us(pwdata[15:0]);
                end
                REG_HB_TIMEOUT: begin
                    r_hb_timeout_ms <= pwdata[15:0];
                    r_hb_timeout_us <= ms_to_us(pwdata[15:0]);
                end
                REG_BATT_FLOOR: begin
                    r_batt_floor <= pwdata[15:0];
                end
                REG_STREAK_LIMIT: begin
                    r_streak_limit <= pwdata[7:0];
                end
                REG_BATT_HOLD: begin
                    r_batt_hold_ms <= pwdata[15:0];
                    r_batt_hold_us <= ms_to_us(pwdata[15:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_TILT_LIMIT:   prdata = 32'(r_tilt_limit);
            REG_MOTOR_SAT:    prdata = 32'(r_motor_sat_ms);
            REG_HB_TIMEOUT:   prdata = 32'(r_hb_timeout_ms);
            REG_BATT_FLOOR:   prdata = 32'(r_batt_floor);
            REG_STREAK_LIMIT: prdata = 32'(r_streak_limit);
            REG_BATT_HOLD:    prdata = 32'(r_batt_hold_ms);
            default:          prdata = '0;
        endcase
    end

    assign cfg.tilt_limit_cdeg      = r_tilt_limit;
    assign cfg.motor_sat_limit_us   = r_motor_sat_us;
    assign cfg.heartbeat_timeout_us = r_hb_timeout_us;
    assign cfg.battery_floor_mv     = r_batt_floor;
    assign cfg.miss_streak_limit    = r_streak_limit;
    assign cfg.battery_hold_us      = r_batt_hold_us;

    // handshake: the result register frees when empty or taken
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= t_sample'(s_axis_tdata[SAMPLE_W-1:0]);
        end
    end

    // fault checks
    ffm_check #(
        .TIME_BITS (TIME_BITS)
    ) u_check (
        .i_sample      (r_in),
        .i_cfg         (cfg),
        .i_last_hb     (r_last_hb),
        .i_motor_start (r_motor_start),
        .i_batt_start  (r_batt_start),
        .o_last_hb     (n_last_hb),
        .o_motor_start (n_motor_start),
        .o_batt_start  (n_batt_start),
        .o_result      (n_out)
    );

    // result register and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_last_hb     <= '0;
            r_motor_start <= '0;
            r_batt_start  <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_last_hb     <= n_last_hb;
                r_motor_start <= n_motor_start;
                r_batt_start  <= n_batt_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 8'(r_out);

`ifndef SYNTHESIS
    // a disarmed word gives no fault and idles the motor timer
    a_disarmed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_valid && (r_in.fsm_mode == MODE_DISARMED)
        |=> (r_out.fault_level == LVL_NONE) && (r_out.fault_reason == RSN_OK)
            && (r_motor_start == '0))
        else $error("disarmed word gave a fault or left the motor timer running");

    // no level without a reason and no reason without a level
    a_level_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.fault_level == LVL_NONE) == (r_out.fault_reason == RSN_OK)))
        else $error("fault level and reason disagree");

    // hard level only for the hard reasons
    a_hard_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.fault_level == LVL_HARD)
        |-> (r_out.fault_reason == RSN_IMU_INVALID) || (r_out.fault_reason == RSN_TILT)
            || (r_out.fault_reason == RSN_DEADLINE) || (r_out.fault_reason == RSN_MOTOR_SAT))
        else $error("hard level with a soft reason");

    // a stalled result holds its word and blocks a full input register
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready && r_in_valid
        |-> !s_axis_tready ##1 (r_out_valid && $stable(r_out)))
        else $error("stalled result lost or input taken without room");
`endif

endmodule
